// ===== sv/srtp_pkg.sv =====
// Shared types and constants for the serial test pattern responder.
// No dependencies; compiled before the interfaces and all modules.
package srtp_pkg;

  // Item kinds carried on the request channel
  typedef enum logic [1:0] {
    FUNC_FRAME    = 2'd0,
    FUNC_TX_READY = 2'd1,
    FUNC_ABORT    = 2'd2
  } func_e;

  // Answer to a command frame
  typedef enum logic [1:0] {
    RSP_NONE        = 2'd0,
    RSP_NOT_HANDLED = 2'd1,
    RSP_NAK         = 2'd2,
    RSP_START       = 2'd3
  } rsp_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEVICE_ID  = 2'd0,
    REG_MAX_SECTOR = 2'd1
  } reg_e;

  localparam logic [7:0]  CMD_READ   = 8'h52;
  localparam logic [7:0]  CMD_STATUS = 8'h53;
  localparam logic [7:0]  CMD_GET    = 8'h47;

  localparam logic [7:0]  COMPLETE_BYTE = 8'h43;

  localparam logic [15:0] READ_LEN   = 16'd128;
  localparam logic [15:0] STATUS_LEN = 16'd4;
  localparam logic [7:0]  GET_BASE   = 8'd1;

  localparam logic [7:0]  DEVICE_ID_RST  = 8'h31;
  localparam logic [15:0] MAX_SECTOR_RST = 16'd720;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned INDEX_W    = 17;

  // Live configuration handed to the core
  typedef struct packed {
    logic [7:0]  device_id;
    logic [15:0] max_sector;
  } cfg_t;

  // One request item
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  device_number;
    logic [7:0]  command_code;
    logic [15:0] aux_word;
    logic        standard_rate;
  } item_t;

  // One result item
  typedef struct packed {
    rsp_e        response;
    logic        byte_valid;
    logic [7:0]  tx_byte;
    logic        command_done;
  } result_t;

endpackage

// ===== sv/srtp_if.sv =====
// Handshake interfaces for the request, result and configuration channels.
// Depends on srtp_pkg for widths.
interface srtp_in_if import srtp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  device_number;
  logic [7:0]  command_code;
  logic [15:0] aux_word;
  logic        standard_rate;

  modport source (output valid, func, device_number, command_code, aux_word,
                  standard_rate, input ready);
  modport sink   (input valid, func, device_number, command_code, aux_word,
                  standard_rate, output ready);
endinterface

interface srtp_out_if import srtp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  response;
  logic        byte_valid;
  logic [7:0]  tx_byte;
  logic        command_done;

  modport source (output valid, response, byte_valid, tx_byte, command_done,
                  input ready);
  modport sink   (input valid, response, byte_valid, tx_byte, command_done,
                  output ready);
endinterface

interface srtp_cfg_if import srtp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/srtp_core.sv =====
// Transfer state and per-request decode: command frames, byte stream, abort.
// Depends on srtp_pkg; state advances only on an accepted request.
module srtp_core import srtp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic               active_q, active_d;
  logic [INDEX_W-1:0] index_q, index_d;
  logic [15:0]        length_q, length_d;
  logic [7:0]         base_q, base_d;
  logic [7:0]         csum_q, csum_d;
  result_t            res;

  logic [INDEX_W-1:0] len_ext;
  logic [7:0]         pat_byte;
  logic [8:0]         csum_sum;

  assign len_ext  = {1'b0, length_q};
  assign pat_byte = index_q[7:0] - 8'd1 + base_q;
  assign csum_sum = {1'b0, csum_q} + {1'b0, pat_byte};

  always_comb begin
    logic        arm;
    logic [15:0] arm_len;
    active_d = active_q;
    index_d  = index_q;
    length_d = length_q;
    base_d   = base_q;
    csum_d   = csum_q;
    res      = '0;
    arm      = 1'b0;
    arm_len  = '0;
    unique case (item_i.func)
      FUNC_FRAME: begin
        if (item_i.device_number != cfg_i.device_id || !item_i.standard_rate) begin
          res.response = RSP_NOT_HANDLED;
        end else begin
          // any frame for us drops a running transfer
          active_d     = 1'b0;
          res.response = RSP_NAK;
          unique case (item_i.command_code)
            CMD_READ: begin
              if (item_i.aux_word != '0 && item_i.aux_word <= cfg_i.max_sector) begin
                base_d  = item_i.aux_word[7:0];
                arm     = 1'b1;
                arm_len = READ_LEN;
              end
            end
            CMD_STATUS: begin
              arm     = 1'b1;
              arm_len = STATUS_LEN;
            end
            CMD_GET: begin
              if (item_i.aux_word != '0) begin
                base_d  = GET_BASE;
                arm     = 1'b1;
                arm_len = item_i.aux_word;
              end
            end
            default: ;
          endcase
          if (arm) begin
            active_d     = 1'b1;
            index_d      = '0;
            length_d     = arm_len;
            csum_d       = '0;
            res.response = RSP_START;
          end
        end
      end
      FUNC_TX_READY: begin
        if (active_q) begin
          priority if (index_q == '0) begin
            res.byte_valid = 1'b1;
            res.tx_byte    = COMPLETE_BYTE;
            index_d        = INDEX_W'(1);
          end else if (index_q <= len_ext + INDEX_W'(1)) begin
            res.byte_valid = 1'b1;
            if (index_q <= len_ext) begin
              res.tx_byte = pat_byte;
              // end-around carry
              csum_d      = csum_sum[7:0] + {7'd0, csum_sum[8]};
            end else begin
              res.tx_byte = csum_q;
            end
            index_d = index_q + INDEX_W'(1);
          end else begin
            active_d         = 1'b0;
            res.command_done = 1'b1;
          end
        end
      end
      FUNC_ABORT: begin
        active_d = 1'b0;
      end
      default: ;
    endcase
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      index_q  <= '0;
      length_q <= '0;
      base_q   <= '0;
      csum_q   <= '0;
    end else if (accept_i) begin
      active_q <= active_d;
      index_q  <= index_d;
      length_q <= length_d;
      base_q   <= base_d;
      csum_q   <= csum_d;
    end
  end

  a_index_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> index_q <= len_ext + INDEX_W'(2))
    else $error("byte index ran past the end of the transfer");

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res.response == RSP_START |=> active_q && index_q == '0)
    else $error("started command did not arm the transfer");

  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res.command_done |=> !active_q)
    else $error("transfer still active after completion");

  a_byte_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res.byte_valid |-> active_q && item_i.func == FUNC_TX_READY)
    else $error("byte emitted without an active transfer");

endmodule

// ===== sv/serial_test_pattern_responder.sv =====
// Top level of the serial test pattern responder: config registers, core, result register.
// Depends on srtp_pkg, srtp_if and srtp_core.
//
//  channel | dir | payload                                             | taken when
//  in_i    | in  | func, device_number, command_code, aux_word, rate   | valid & ready
//  out_o   | out | response, byte_valid, tx_byte, command_done         | valid & ready
//  cfg_i   | in  | index (0 device_id, 1 max_sector), data             | valid & ready
//
// One request per cycle, one result per request, registered in the result register
// and held there until taken. The request decode and checksum add sit between the
// request port and that register. in_i.ready drops only while a result waits
// and out_o.ready is low. cfg_i.ready is always high. Reset is asynchronous and
// clears the transfer state and loads the register defaults.
module serial_test_pattern_responder import srtp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  srtp_in_if.sink    in_i,
  srtp_out_if.source out_o,
  srtp_cfg_if.sink   cfg_i
);

  cfg_t    cfg_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res;
  item_t   item;
  logic    accept;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign item.func          = in_i.func;
  assign item.device_number = in_i.device_number;
  assign item.command_code  = in_i.command_code;
  assign item.aux_word      = in_i.aux_word;
  assign item.standard_rate = in_i.standard_rate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_id  <= DEVICE_ID_RST;
      cfg_q.max_sector <= MAX_SECTOR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DEVICE_ID:  cfg_q.device_id  <= cfg_i.data[7:0];
        REG_MAX_SECTOR: cfg_q.max_sector <= cfg_i.data;
        default: ;
      endcase
    end
  end

  srtp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.response     = res_q.response;
  assign out_o.byte_valid   = res_q.byte_valid;
  assign out_o.tx_byte      = res_q.tx_byte;
  assign out_o.command_done = res_q.command_done;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for serial_test_pattern_responder: directed, register,
// backpressure and random traffic checked against an in-bench predictor.
// Depends on srtp_pkg, srtp_if and the responder RTL.
module tb_top import srtp_pkg::*; ();

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [7:0] CMD_UNKNOWN = 8'hFF;
  localparam int unsigned ITEM_TARGET = 550;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned IDLE_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n;

  srtp_in_if  in_if ();
  srtp_out_if out_if ();
  srtp_cfg_if cfg_if ();

  serial_test_pattern_responder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and register copies
  logic        st_active;
  logic [16:0] st_index;
  logic [15:0] st_length;
  logic [7:0]  st_base;
  logic [7:0]  st_sum;
  logic [7:0]  cfg_device;
  logic [15:0] cfg_max_sector;

  result_t awaited[$];
  result_t want;

  bit          no_gaps = 1'b0;
  int unsigned hold_off_len = 0;
  int unsigned mismatches = 0;
  int unsigned useful_items = 0;
  int unsigned sent_items = 0;
  int unsigned results_seen = 0;
  int unsigned transfers_done = 0;
  int unsigned starts = 0;
  int unsigned naks = 0;
  int unsigned reg_writes = 0;

  function automatic void arm_transfer(input logic [15:0] len);
    st_index  = '0;
    st_length = len;
    st_sum    = '0;
    st_active = 1'b1;
  endfunction

  // Advance the predicted state by one request and return its result
  function automatic result_t respond_to(input item_t it);
    result_t    r;
    logic [7:0] b;
    logic [8:0] s;
    r.response     = RSP_NONE;
    r.byte_valid   = 1'b0;
    r.tx_byte      = '0;
    r.command_done = 1'b0;
    case (it.func)
      FUNC_FRAME: begin
        if (it.device_number != cfg_device || !it.standard_rate) begin
          r.response = RSP_NOT_HANDLED;
        end else begin
          st_active  = 1'b0;
          r.response = RSP_NAK;
          if (it.command_code == CMD_READ) begin
            if (it.aux_word != 0 && it.aux_word <= cfg_max_sector) begin
              st_base = it.aux_word[7:0];
              arm_transfer(READ_LEN);
              r.response = RSP_START;
            end
          end else if (it.command_code == CMD_STATUS) begin
            arm_transfer(STATUS_LEN);
            r.response = RSP_START;
          end else if (it.command_code == CMD_GET) begin
            if (it.aux_word != 0) begin
              st_base = GET_BASE;
              arm_transfer(it.aux_word);
              r.response = RSP_START;
            end
          end
        end
      end
      FUNC_TX_READY: begin
        if (st_active) begin
          if (st_index == 0) begin
            r.byte_valid = 1'b1;
            r.tx_byte    = COMPLETE_BYTE;
            st_index     = 17'd1;
          end else if (st_index <= {1'b0, st_length} + 17'd1) begin
            r.byte_valid = 1'b1;
            if (st_index <= {1'b0, st_length}) begin
              b = st_index[7:0] - 8'd1 + st_base;
              s = {1'b0, st_sum} + {1'b0, b};
              // fold the carry back in
              st_sum    = s[7:0] + {7'd0, s[8]};
              r.tx_byte = b;
            end else begin
              r.tx_byte = st_sum;
            end
            st_index = st_index + 17'd1;
          end else begin
            st_active      = 1'b0;
            r.command_done = 1'b1;
          end
        end
      end
      FUNC_ABORT: st_active = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t make_item(input logic [1:0] f, input logic [7:0] dev,
                                      input logic [7:0] cmd, input logic [15:0] aux,
                                      input logic rate);
    item_t it;
    it.func          = f;
    it.device_number = dev;
    it.command_code  = cmd;
    it.aux_word      = aux;
    it.standard_rate = rate;
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input item_t it);
    int unsigned gap;
    @(negedge clk);
    in_if.valid         = 1'b1;
    in_if.func          = it.func;
    in_if.device_number = it.device_number;
    in_if.command_code  = it.command_code;
    in_if.aux_word      = it.aux_word;
    in_if.standard_rate = it.standard_rate;
    do @(posedge clk); while (!in_if.ready);
    sent_items++;
    if (it.func == FUNC_FRAME || (st_active && (it.func == FUNC_TX_READY ||
                                                 it.func == FUNC_ABORT)))
      useful_items++;
    awaited.push_back(respond_to(it));
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] aux);
    send_request(make_item(FUNC_FRAME, cfg_device, cmd, aux, 1'b1));
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n)
      send_request(make_item(FUNC_TX_READY, 8'($urandom), 8'($urandom),
                             16'($urandom), 1'($urandom)));
  endtask

  task automatic send_abort();
    send_request(make_item(FUNC_ABORT, 8'($urandom), 8'($urandom),
                           16'($urandom), 1'($urandom)));
  endtask

  // Drop valid, drain all results, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_e idx, input logic [15:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_DEVICE_ID) cfg_device = value[7:0];
    else cfg_max_sector = value;
    reg_writes++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic test_directed_commands();
    send_request(make_item(FUNC_FRAME, DEVICE_ID_RST - 8'd1, CMD_READ, 16'd1, 1'b1));
    send_request(make_item(FUNC_FRAME, DEVICE_ID_RST, CMD_STATUS, 16'd0, 1'b0));
    send_ticks(1);
    send_request(make_item(FUNC_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 1'b1));
    send_frame(CMD_READ, 16'd0);
    send_frame(CMD_READ, MAX_SECTOR_RST + 16'd1);
    send_frame(CMD_GET, 16'd0);
    send_frame(CMD_UNKNOWN, 16'd5);
    // full status transfer, then one tick past the end
    send_frame(CMD_STATUS, 16'd0);
    send_ticks(8);
    send_frame(CMD_READ, MAX_SECTOR_RST);
    send_ticks(2);
    send_abort();
    send_ticks(1);
    // a new frame cuts a long get short
    send_frame(CMD_GET, 16'hFFFF);
    send_ticks(2);
    send_frame(CMD_STATUS, 16'd0);
    send_ticks(3);
    send_abort();
  endtask

  task automatic test_register_settings();
    wait_idle();
    write_register(REG_DEVICE_ID, 16'hFF00);
    write_register(REG_MAX_SECTOR, 16'd1);
    send_frame(CMD_READ, 16'd1);
    send_ticks(3);
    send_frame(CMD_READ, 16'd2);
    send_request(make_item(FUNC_FRAME, DEVICE_ID_RST, CMD_STATUS, 16'd0, 1'b1));
    wait_idle();
    write_register(REG_DEVICE_ID, 16'h00FF);
    write_register(REG_MAX_SECTOR, 16'hFFFF);
    send_frame(CMD_READ, 16'hFFFF);
    send_ticks(4);
    send_abort();
    wait_idle();
    write_register(REG_DEVICE_ID, {8'd0, DEVICE_ID_RST});
    write_register(REG_MAX_SECTOR, MAX_SECTOR_RST);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    no_gaps      = 1'b1;
    hold_off_len = 300;
    send_frame(CMD_STATUS, 16'd0);
    send_ticks(8);
    send_frame(CMD_GET, 16'd20);
    send_ticks(23);
    no_gaps = 1'b0;
  endtask

  task automatic reprogram_registers();
    int unsigned pick;
    wait_idle();
    write_register(REG_DEVICE_ID, 16'($urandom));
    pick = $urandom_range(3);
    case (pick)
      0: write_register(REG_MAX_SECTOR, 16'd1);
      1: write_register(REG_MAX_SECTOR, 16'hFFFF);
      2: write_register(REG_MAX_SECTOR, MAX_SECTOR_RST);
      default: write_register(REG_MAX_SECTOR, 16'($urandom_range(1, 65535)));
    endcase
  endtask

  task automatic run_command_sequence();
    logic [7:0]  cmd;
    logic [15:0] aux;
    int unsigned pick;
    int unsigned total;
    pick = $urandom_range(19);
    if (pick < 3) begin
      cmd = CMD_READ;
      if ($urandom_range(9) != 0)
        aux = 16'($urandom_range(1, cfg_max_sector));
      else if (cfg_max_sector == 16'hFFFF || $urandom_range(1) == 0)
        aux = 16'd0;
      else
        aux = 16'($urandom_range(cfg_max_sector + 1, 65535));
    end else if (pick < 8) begin
      cmd = CMD_STATUS;
      aux = 16'($urandom);
    end else begin
      cmd = CMD_GET;
      if (pick == 19) aux = 16'($urandom_range(100, 300));
      else if ($urandom_range(19) == 0) aux = 16'd0;
      else aux = 16'($urandom_range(1, 24));
    end
    send_frame(cmd, aux);
    if (!st_active) return;
    total = int'(st_length) + 3;
    pick  = $urandom_range(9);
    if (pick < 7) begin
      send_ticks(total + $urandom_range(2));
    end else begin
      send_ticks($urandom_range(total - 1));
      // otherwise leave it running for the next frame to stop
      if (pick < 9) send_abort();
    end
  endtask

  task automatic send_noise(input int unsigned n);
    logic [7:0] dev;
    logic [7:0] cmd;
    repeat (n) begin
      dev = $urandom_range(1) ? cfg_device : 8'($urandom);
      case ($urandom_range(4))
        0: cmd = CMD_READ;
        1: cmd = CMD_STATUS;
        2: cmd = CMD_GET;
        default: cmd = 8'($urandom);
      endcase
      send_request(make_item(2'($urandom), dev, cmd, 16'($urandom), 1'($urandom)));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase_mark;
    phase_mark = useful_items;
    while (useful_items < ITEM_TARGET) begin
      if (useful_items - phase_mark >= 100) begin
        reprogram_registers();
        phase_mark = useful_items;
        no_gaps    = ($urandom_range(3) == 0);
      end
      if ($urandom_range(9) < 7) run_command_sequence();
      else send_noise($urandom_range(1, 4));
    end
    no_gaps = 1'b0;
  endtask

  // Result receiver: random stalls, plus one long hold when requested
  initial begin : result_receiver
    int unsigned stall;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        stall        = hold_off_len;
        hold_off_len = 0;
      end else if (!no_gaps && $urandom_range(99) < 30) begin
        stall = pick_stall();
      end else begin
        stall = 0;
      end
      out_if.ready = (stall == 0);
      if (stall > 1) repeat (stall - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: rsp %0d valid %0b byte %02h done %0b",
                   $time, out_if.response, out_if.byte_valid, out_if.tx_byte,
                   out_if.command_done);
      end else begin
        want = awaited.pop_front();
        if (want.response == RSP_START) starts++;
        if (want.response == RSP_NAK) naks++;
        if (want.command_done) transfers_done++;
        if (out_if.response !== want.response || out_if.byte_valid !== want.byte_valid ||
            out_if.tx_byte !== want.tx_byte || out_if.command_done !== want.command_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: want rsp %0d valid %0b byte %02h done %0b, %s %0d %0b %02h %0b",
                     $time, want.response, want.byte_valid, want.tx_byte,
                     want.command_done, "got", out_if.response, out_if.byte_valid,
                     out_if.tx_byte, out_if.command_done);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no handshake for %0d cycles, %0d results pending",
             IDLE_LIMIT, awaited.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.func          = '0;
    in_if.device_number = '0;
    in_if.command_code  = '0;
    in_if.aux_word      = '0;
    in_if.standard_rate = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    rst_n               = 1'b0;
    st_active           = 1'b0;
    st_index            = '0;
    st_length           = '0;
    st_base             = '0;
    st_sum              = '0;
    cfg_device          = DEVICE_ID_RST;
    cfg_max_sector      = MAX_SECTOR_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_commands();
    test_register_settings();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();

    $display("Sent %0d requests (%0d acted on), checked %0d results, %0d register writes.",
             sent_items, useful_items, results_seen, reg_writes);
    $display("Commands started %0d, NAKs %0d, transfers run to completion %0d.",
             starts, naks, transfers_done);
    if (mismatches == 0 && awaited.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
